// File: src/priority_scheduler_with_aging_assert.svh
// Assertion macros used by the scheduler controller (psa_ctrl).
// Each expects signals named clk and rst_n in the scope where it is used.
`ifndef PRIORITY_SCHEDULER_WITH_AGING_ASSERT_SVH
`define PRIORITY_SCHEDULER_WITH_AGING_ASSERT_SVH

// Same-cycle implication.
`define PSA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psa: implication check failed");

// Next-cycle implication.
`define PSA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psa: next-cycle check failed");

`endif

// File: src/psa_pkg.sv
package psa_pkg;

    localparam int MAX_JOBS = 8;
    localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);

    localparam int PRIO_W   = 4;
    localparam int ARR_W    = 8;
    localparam int BURST_W  = 8;
    localparam int WAIT_W   = 11;
    localparam int TIME_W   = 11;
    localparam int START_W  = 10;
    localparam int SHIFT_W  = 3;
    localparam int JIDX_W   = 3;

    localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_AGING_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGING_SHIFT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_LIMIT   = 2'd2;

    localparam logic                  RST_AGING_ENABLE = 1'b1;
    localparam logic [SHIFT_W-1:0]    RST_AGING_SHIFT  = 3'd1;
    localparam logic [START_W-1:0]    RST_TIME_LIMIT   = 10'd30;

    // Controller to datapath
    typedef struct packed {
        logic load;         // item transfer
        logic run_init;     // clear time, finish count, pending burst
        logic scan_init;    // restart entry counter and selection
        logic scan_step;    // age and compare one entry
        logic dispatch;     // commit selection or advance time by one
        logic report_init;  // restart entry counter for reports
        logic report_step;  // emit one report
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic run_over;     // all jobs done or time limit reached
        logic last_entry;   // entry counter on the final loaded job
    } status_t;

    function automatic logic [PRIO_W-1:0] aged_priority(
        input logic [PRIO_W-1:0]  base,
        input logic [WAIT_W-1:0]  wait_v,
        input logic [SHIFT_W-1:0] shift
    );
        logic [WAIT_W-1:0] gain;
        logic [PRIO_W-1:0] result;
        gain = wait_v >> shift;
        if ({1'b0, {(WAIT_W - PRIO_W){1'b0}}, base} > ({1'b0, gain} + 12'd1))
        begin
            result = base - gain[PRIO_W-1:0];
        end
        else
        begin
            result = 4'd1;
        end
        return result;
    endfunction

endpackage

// File: src/psa_ctrl.sv
`include "priority_scheduler_with_aging_assert.svh"

module psa_ctrl import psa_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    last_job,
    input  status_t status,
    output logic    busy,
    output cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_CHECK    = 3'd1;
    localparam logic [2:0] ST_SCAN     = 3'd2;
    localparam logic [2:0] ST_DISPATCH = 3'd3;
    localparam logic [2:0] ST_REPORT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load     = accept;
                cmd.run_init = accept && last_job;
                if (accept && last_job)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.run_over)
                begin
                    cmd.report_init = 1'b1;
                    state_next      = ST_REPORT;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.last_entry)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                cmd.dispatch = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_REPORT:
            begin
                cmd.report_step = 1'b1;
                if (status.last_entry)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `PSA_ASSERT_NXT(a_run_starts, accept && last_job, state_reg == ST_CHECK)
    `PSA_ASSERT_NXT(a_dispatch_returns, state_reg == ST_DISPATCH, state_reg == ST_CHECK)
    `PSA_ASSERT_NXT(a_scan_holds, (state_reg == ST_SCAN) && !status.last_entry,
                    state_reg == ST_SCAN)
    `PSA_ASSERT_NXT(a_report_ends, cmd.report_step && status.last_entry,
                    (state_reg == ST_IDLE) && !busy)

endmodule

// File: src/psa_datapath.sv
module psa_datapath import psa_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [PRIO_W-1:0]     base_priority,
    input  logic [ARR_W-1:0]      arrival_time,
    input  logic [BURST_W-1:0]    burst_length,
    output logic                  result_valid,
    output logic [JIDX_W-1:0]     job_index,
    output logic                  completed,
    output logic [START_W-1:0]    start_time,
    output logic [PRIO_W-1:0]     dispatch_priority,
    output logic [WAIT_W-1:0]     total_wait,
    output logic                  last_report
);

    // Configuration
    logic                 aging_enable_reg;
    logic [SHIFT_W-1:0]   aging_shift_reg;
    logic [START_W-1:0]   time_limit_reg;

    // Job table
    logic [PRIO_W-1:0]    base_reg  [MAX_JOBS];
    logic [ARR_W-1:0]     arr_reg   [MAX_JOBS];
    logic [BURST_W-1:0]   burst_reg [MAX_JOBS];
    logic [PRIO_W-1:0]    eff_reg   [MAX_JOBS];
    logic [WAIT_W-1:0]    wait_reg  [MAX_JOBS];
    logic [START_W-1:0]   start_reg [MAX_JOBS];
    logic [MAX_JOBS-1:0]  done_reg;

    // Run state
    logic [CNT_W-1:0]     loaded_reg;
    logic [CNT_W-1:0]     finished_reg;
    logic [TIME_W-1:0]    time_reg;
    logic [BURST_W-1:0]   pend_reg;
    logic [IDX_W-1:0]     entry_reg;
    logic                 best_valid_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [PRIO_W-1:0]    best_eff_reg;
    logic [BURST_W-1:0]   best_burst_reg;

    // Report outputs
    logic                 result_valid_reg;
    logic [JIDX_W-1:0]    job_index_reg;
    logic                 completed_reg;
    logic [START_W-1:0]   start_time_reg;
    logic [PRIO_W-1:0]    dispatch_priority_reg;
    logic [WAIT_W-1:0]    total_wait_reg;
    logic                 last_report_reg;

    logic [IDX_W-1:0]     load_idx;
    logic                 table_full;
    logic                 cand;
    logic [WAIT_W:0]      wait_sum;
    logic [WAIT_W-1:0]    wait_upd;
    logic [PRIO_W-1:0]    eff_upd;
    logic                 better;

    assign load_idx   = loaded_reg[IDX_W-1:0];
    assign table_full = (loaded_reg >= CNT_W'(MAX_JOBS));

    // Current entry: fold in the burst of the previous dispatch, then age.
    assign cand     = !done_reg[entry_reg]
                      && ({{(TIME_W - ARR_W){1'b0}}, arr_reg[entry_reg]} <= time_reg);
    assign wait_sum = {1'b0, wait_reg[entry_reg]}
                      + {{(WAIT_W + 1 - BURST_W){1'b0}}, pend_reg};
    assign wait_upd = !cand ? wait_reg[entry_reg]
                      : (wait_sum > {1'b0, WAIT_MAX}) ? WAIT_MAX : wait_sum[WAIT_W-1:0];
    assign eff_upd  = (aging_enable_reg && cand && (wait_upd != '0))
                      ? aged_priority(base_reg[entry_reg], wait_upd, aging_shift_reg)
                      : eff_reg[entry_reg];
    assign better   = cand && (!best_valid_reg || (eff_upd < best_eff_reg));

    assign status.run_over   = (finished_reg == loaded_reg)
                               || (time_reg >= {1'b0, time_limit_reg});
    assign status.last_entry = (CNT_W'(entry_reg) == (loaded_reg - CNT_W'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aging_enable_reg <= RST_AGING_ENABLE;
            aging_shift_reg  <= RST_AGING_SHIFT;
            time_limit_reg   <= RST_TIME_LIMIT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_AGING_ENABLE: aging_enable_reg <= cfg_data[0];
                CFG_AGING_SHIFT:  aging_shift_reg  <= cfg_data[SHIFT_W-1:0];
                CFG_TIME_LIMIT:   time_limit_reg   <= cfg_data[START_W-1:0];
                default:          ;
            endcase
        end
    end

    // Control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg       <= '0;
            finished_reg     <= '0;
            time_reg         <= '0;
            pend_reg         <= '0;
            entry_reg        <= '0;
            best_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.report_step;
            if (cmd.load && !table_full)
            begin
                loaded_reg <= loaded_reg + CNT_W'(1);
            end
            if (cmd.run_init)
            begin
                finished_reg <= '0;
                time_reg     <= '0;
                pend_reg     <= '0;
            end
            if (cmd.scan_init || cmd.report_init)
            begin
                entry_reg      <= '0;
                best_valid_reg <= 1'b0;
            end
            if (cmd.scan_step || cmd.report_step)
            begin
                entry_reg <= entry_reg + IDX_W'(1);
            end
            if (cmd.scan_step && better)
            begin
                best_valid_reg <= 1'b1;
            end
            if (cmd.dispatch)
            begin
                if (best_valid_reg)
                begin
                    time_reg     <= time_reg + {{(TIME_W - BURST_W){1'b0}}, best_burst_reg};
                    finished_reg <= finished_reg + CNT_W'(1);
                    pend_reg     <= best_burst_reg;
                end
                else
                begin
                    time_reg <= time_reg + TIME_W'(1);
                    pend_reg <= '0;
                end
            end
            if (cmd.report_step && status.last_entry)
            begin
                loaded_reg <= '0;
            end
        end
    end

    // Job table and selection payload
    always_ff @(posedge clk)
    begin
        if (cmd.load && !table_full)
        begin
            base_reg[load_idx]  <= base_priority;
            arr_reg[load_idx]   <= arrival_time;
            burst_reg[load_idx] <= burst_length;
            eff_reg[load_idx]   <= base_priority;
            wait_reg[load_idx]  <= '0;
            start_reg[load_idx] <= '0;
            done_reg[load_idx]  <= 1'b0;
        end
        if (cmd.scan_step)
        begin
            wait_reg[entry_reg] <= wait_upd;
            eff_reg[entry_reg]  <= eff_upd;
            if (better)
            begin
                best_idx_reg   <= entry_reg;
                best_eff_reg   <= eff_upd;
                best_burst_reg <= burst_reg[entry_reg];
            end
        end
        if (cmd.dispatch && best_valid_reg)
        begin
            start_reg[best_idx_reg] <= time_reg[START_W-1:0];
            done_reg[best_idx_reg]  <= 1'b1;
        end
        if (cmd.report_step)
        begin
            job_index_reg         <= JIDX_W'(entry_reg);
            completed_reg         <= done_reg[entry_reg];
            start_time_reg        <= start_reg[entry_reg];
            dispatch_priority_reg <= eff_reg[entry_reg];
            total_wait_reg        <= wait_upd;
            last_report_reg       <= status.last_entry;
        end
    end

    assign result_valid      = result_valid_reg;
    assign job_index         = job_index_reg;
    assign completed         = completed_reg;
    assign start_time        = start_time_reg;
    assign dispatch_priority = dispatch_priority_reg;
    assign total_wait        = total_wait_reg;
    assign last_report       = last_report_reg;

endmodule

// File: src/priority_scheduler_with_aging.sv
// Channel   Handshake                   Payload
// -------   -------------------------   ------------------------------------------------
// job in    start & !busy               base_priority, arrival_time, burst_length,
//                                       last_job
// config    cfg_write                   cfg_index, cfg_data
// report    result_valid (one cycle)    job_index, completed, start_time,
//                                       dispatch_priority, total_wait, last_report
//
// A job without last_job loads while busy stays low.
// A job with last_job starts the run: each step is a check, a scan of every loaded
// job and a dispatch; after one final check, one report per loaded job follows.
// Reset clears the controller and counters and restores the configuration defaults; the job table needs no clear.
// Reports come out one per cycle and cannot be stalled by the receiver.
module priority_scheduler_with_aging import psa_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [PRIO_W-1:0]     base_priority,
    input  logic [ARR_W-1:0]      arrival_time,
    input  logic [BURST_W-1:0]    burst_length,
    input  logic                  last_job,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  result_valid,
    output logic [JIDX_W-1:0]     job_index,
    output logic                  completed,
    output logic [START_W-1:0]    start_time,
    output logic [PRIO_W-1:0]     dispatch_priority,
    output logic [WAIT_W-1:0]     total_wait,
    output logic                  last_report
);

    cmd_t    cmd;
    status_t status;

    psa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .last_job (last_job),
        .status   (status),
        .busy     (busy),
        .cmd      (cmd)
    );

    psa_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .base_priority     (base_priority),
        .arrival_time      (arrival_time),
        .burst_length      (burst_length),
        .result_valid      (result_valid),
        .job_index         (job_index),
        .completed         (completed),
        .start_time        (start_time),
        .dispatch_priority (dispatch_priority),
        .total_wait        (total_wait),
        .last_report       (last_report)
    );

endmodule
